// ===== sv/assert_macros.svh =====
// Assertion macros used by the extractor top-level unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset
`define CHK_ALWAYS(lbl, c, r, p, msg) \
  lbl: assert property (@(posedge c) disable iff (r) (p)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define CHK_NEXT(lbl, c, r, a, b, msg) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define CHK_SAME(lbl, c, r, a, b, msg) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |-> (b)) else $error(msg);

`endif

// ===== sv/adne_pkg.sv =====
// Types and constants for the advertising-data name extractor
`default_nettype none

package adne_pkg;

  localparam int CAP_W      = 7;
  localparam int CHAR_W     = 7;
  localparam int NAME_LEN_W = 6;
  localparam int KIND_W     = 2;

  localparam logic [CAP_W-1:0]  CAP_RESET     = 7'd32;
  localparam logic [7:0]        TYPE_COMPLETE = 8'h09;
  localparam logic [7:0]        TYPE_SHORT    = 8'h08;
  localparam logic [7:0]        PRINT_LO      = 8'd32;
  localparam logic [7:0]        PRINT_HI      = 8'd127;
  localparam logic [CHAR_W-1:0] DOT_CHAR      = 7'h2E;

  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SHORT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd2;

  typedef struct packed {
    logic [7:0] ad_byte;
    logic       packet_end;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]     name_char;
    logic [NAME_LEN_W-1:0] name_length;
    logic [KIND_W-1:0]     name_kind;
    logic                  end_of_name;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_TYPE,
    PH_DATA,
    PH_DONE
  } parse_phase_t;

  typedef enum logic [1:0] {
    ST_PARSE,
    ST_READ,
    ST_SHOW
  } ctrl_state_t;

  typedef struct packed {
    logic parse;
    logic start;
    logic read;
    logic advance;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/adne_ctrl.sv =====
// Controller: sequences byte parsing and the name emission burst
`default_nettype none

module adne_ctrl import adne_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       packet_end,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output logic            in_ready,
  output logic            out_valid,
  output ctrl_cmd_t       cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_PARSE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_PARSE: begin
        in_ready  = 1'b1;
        cmd.parse = in_valid;
        if (in_valid && packet_end) begin
          cmd.start  = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.empty || status.last) begin
            // burst done: drop the parse state
            cmd.finish = 1'b1;
            state_next = ST_PARSE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_PARSE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/adne_dp.sv =====
// Datapath: record walker, two-bank name store and result register
`default_nettype none

module adne_dp import adne_pkg::*; #(
  parameter int NAME_MAX = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_data,
  input  wire in_item_t         in_item,
  input  wire ctrl_cmd_t        cmd,
  output dp_status_t            status,
  output out_item_t             out_item
);

  localparam int AW = $clog2(NAME_MAX);
  localparam int DEPTH = 2 * (2 ** AW);
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(NAME_MAX);

  logic [CHAR_W-1:0] name_mem [0:DEPTH-1];
  logic [CHAR_W-1:0] rdata;

  logic [CAP_W-1:0]  capacity;
  parse_phase_t      phase;
  logic [7:0]        bytes_left;
  logic [KIND_W-1:0] category;
  logic [KIND_W-1:0] best_level;
  logic              bank;
  logic [AW-1:0]     staged_length;
  logic [AW-1:0]     kept_length;
  logic [AW-1:0]     char_idx;

  logic [CAP_W-1:0]  cap_eff;
  logic [CAP_W-1:0]  keep_limit;
  logic [7:0]        left_dec;
  logic              store_ok;
  logic [AW-1:0]     staged_after;
  logic [CHAR_W-1:0] clean_char;
  logic [7:0]        b;

  assign b = in_item.ad_byte;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = CAP_W'(1);
    end else if (capacity > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = capacity;
    end
    keep_limit   = cap_eff - CAP_W'(1);
    left_dec     = bytes_left - 8'd1;
    store_ok     = (category != KIND_NONE) && (CAP_W'(staged_length) < keep_limit);
    staged_after = store_ok ? staged_length + AW'(1) : staged_length;
    clean_char   = (b >= PRINT_LO && b < PRINT_HI) ? b[CHAR_W-1:0] : DOT_CHAR;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // parse state; bank select survives the end-of-packet clear
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEN;
      bytes_left    <= '0;
      category      <= KIND_NONE;
      best_level    <= KIND_NONE;
      bank          <= 1'b0;
      staged_length <= '0;
      kept_length   <= '0;
    end else if (cmd.finish) begin
      phase         <= PH_LEN;
      bytes_left    <= '0;
      category      <= KIND_NONE;
      best_level    <= KIND_NONE;
      staged_length <= '0;
      kept_length   <= '0;
    end else if (cmd.parse) begin
      case (phase)
        PH_LEN: begin
          if (b == 8'd0) begin
            phase <= PH_DONE;
          end else begin
            bytes_left <= b;
            phase      <= PH_TYPE;
          end
        end
        PH_TYPE: begin
          bytes_left <= left_dec;
          if (b == TYPE_COMPLETE) begin
            category <= KIND_COMPLETE;
          end else if (b == TYPE_SHORT && best_level == KIND_NONE) begin
            category <= KIND_SHORT;
          end else begin
            category <= KIND_NONE;
          end
          staged_length <= '0;
          phase         <= (left_dec == 8'd0) ? PH_LEN : PH_DATA;
        end
        PH_DATA: begin
          staged_length <= staged_after;
          bytes_left    <= left_dec;
          if (left_dec == 8'd0) begin
            phase <= PH_LEN;
            if (category != KIND_NONE) begin
              // record complete: the staged bank becomes the kept name
              bank        <= ~bank;
              kept_length <= staged_after;
              best_level  <= category;
              if (category == KIND_COMPLETE) begin
                phase <= PH_DONE;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.parse && phase == PH_DATA && store_ok) begin
      name_mem[{~bank, staged_length}] <= clean_char;
    end
    if (cmd.read) begin
      rdata <= name_mem[{bank, char_idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_idx <= '0;
    end else if (cmd.start) begin
      char_idx <= '0;
    end else if (cmd.advance) begin
      char_idx <= char_idx + AW'(1);
    end
  end

  always_comb begin
    status.empty = (best_level == KIND_NONE) || (kept_length == '0);
    status.last  = ({1'b0, char_idx} + (AW+1)'(1)) == {1'b0, kept_length};
    out_item.name_char   = status.empty ? '0 : rdata;
    out_item.name_length = NAME_LEN_W'(kept_length);
    out_item.name_kind   = best_level;
    out_item.end_of_name = status.empty || status.last;
  end

endmodule

`default_nettype wire

// ===== sv/adv_data_name_extractor_unit.sv =====
// Parses advertising-data bytes, one byte per cycle outside the emission burst.
// On a final byte the name store is read into the result register before the first
// result is valid; each further character takes a name store read, then the result
// register, plus output stalls. No byte is accepted during the emission burst. Config
// writes take effect in the next cycle. Reset (rst, synchronous): capacity 32, parse
// state and bank select cleared; the name store is not cleared, shown only where written.
`default_nettype none
`include "assert_macros.svh"

module adv_data_name_extractor_unit import adne_pkg::*; #(
  parameter int NAME_MAX = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_item
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  adne_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .packet_end (in_item.packet_end),
    .out_ready  (out_ready),
    .status     (status),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .cmd        (cmd)
  );

  adne_dp #(
    .NAME_MAX (NAME_MAX)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

  `CHK_ALWAYS(a_no_overlap, clk, rst, !(in_ready && out_valid),
              "input and output both open")
  `CHK_NEXT(a_burst_blocks, clk, rst, in_valid && in_ready && in_item.packet_end,
            !in_ready, "input open after final byte")
  `CHK_NEXT(a_burst_ends, clk, rst, out_valid && out_ready && out_item.end_of_name,
            in_ready && !out_valid, "parser not resumed after last item")
  `CHK_SAME(a_char_has_len, clk, rst, out_valid && !out_item.end_of_name,
            out_item.name_length != 0 && out_item.name_kind != KIND_NONE,
            "mid-run item without a name")

endmodule

`default_nettype wire

// ===== tb/adne_checker.sv =====
// Checker for the name extractor: tracks the parse, predicts the name items, compares them
`timescale 1ns / 100ps

module adne_checker import adne_pkg::*; #(
  parameter int NAME_MAX = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_data,
  input  wire logic             in_valid,
  input  wire logic             in_ready,
  input  wire in_item_t         in_item,
  input  wire logic             out_valid,
  input  wire logic             out_ready,
  input  wire out_item_t        out_item,
  output int                    fail_count,
  output int                    pending,
  output int                    chars_checked
);

  logic [CAP_W-1:0] capacity_q;
  parse_phase_t     phase_q;
  logic [7:0]       left_q;
  logic [1:0]       category_q;
  logic [1:0]       best_q;
  logic [6:0]       name_store [0:2*NAME_MAX-1];
  logic             bank_q;
  logic [6:0]       staged_q;
  logic [6:0]       kept_q;
  out_item_t        expected_chars [$];

  function automatic int keep_limit();
    int c;
    c = capacity_q;
    if (c == 0) c = 1;
    if (c > NAME_MAX) c = NAME_MAX;
    return c - 1;
  endfunction

  task automatic clear_parse();
    phase_q    = PH_LEN;
    left_q     = '0;
    category_q = KIND_NONE;
    best_q     = KIND_NONE;
    staged_q   = '0;
    kept_q     = '0;
  endtask

  task automatic parse_ad_byte(input logic [7:0] b);
    int         slot;
    logic [6:0] ch;
    case (phase_q)
      PH_LEN: begin
        if (b == 8'd0) begin
          phase_q = PH_DONE;
        end else begin
          left_q  = b;
          phase_q = PH_TYPE;
        end
      end
      PH_TYPE: begin
        left_q = left_q - 8'd1;
        if (b == TYPE_COMPLETE) category_q = KIND_COMPLETE;
        else if (b == TYPE_SHORT && best_q == KIND_NONE) category_q = KIND_SHORT;
        else category_q = KIND_NONE;
        staged_q = '0;
        phase_q  = (left_q == 8'd0) ? PH_LEN : PH_DATA;
      end
      PH_DATA: begin
        if (category_q != KIND_NONE && int'(staged_q) < keep_limit()) begin
          // stage into the bank that is not holding the kept name
          slot = (bank_q ? 0 : NAME_MAX) + int'(staged_q);
          ch = (b >= PRINT_LO && b < PRINT_HI) ? b[6:0] : DOT_CHAR;
          name_store[slot] = ch;
          staged_q = staged_q + 7'd1;
        end
        left_q = left_q - 8'd1;
        if (left_q == 8'd0) begin
          phase_q = PH_LEN;
          if (category_q != KIND_NONE) begin
            bank_q = ~bank_q;
            kept_q = staged_q;
            best_q = category_q;
            if (category_q == KIND_COMPLETE) phase_q = PH_DONE;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_name();
    out_item_t e;
    int        k;
    if (best_q == KIND_NONE || kept_q == 7'd0) begin
      e.name_char   = '0;
      e.name_length = '0;
      e.name_kind   = best_q;
      e.end_of_name = 1'b1;
      expected_chars.push_back(e);
    end else begin
      for (k = 0; k < int'(kept_q); k++) begin
        e.name_char   = name_store[(bank_q ? NAME_MAX : 0) + k];
        e.name_length = kept_q[NAME_LEN_W-1:0];
        e.name_kind   = best_q;
        e.end_of_name = (k + 1 == int'(kept_q));
        expected_chars.push_back(e);
      end
    end
    clear_parse();
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    // keep the log short when the block is badly off
    if (fail_count < 100)
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic check_name_item();
    out_item_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch("name item with nothing pending, char", out_item.name_char, 0);
    end else begin
      want = expected_chars.pop_front();
      chars_checked++;
      if (out_item.name_char !== want.name_char)
        report_mismatch("name_char", out_item.name_char, want.name_char);
      if (out_item.name_length !== want.name_length)
        report_mismatch("name_length", out_item.name_length, want.name_length);
      if (out_item.name_kind !== want.name_kind)
        report_mismatch("name_kind", out_item.name_kind, want.name_kind);
      if (out_item.end_of_name !== want.end_of_name)
        report_mismatch("end_of_name", out_item.end_of_name, want.end_of_name);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      capacity_q = CAP_RESET;
      bank_q     = 1'b0;
      clear_parse();
      expected_chars.delete();
    end else begin
      if (cfg_valid && cfg_ready) capacity_q = cfg_data;
      if (in_valid && in_ready) begin
        parse_ad_byte(in_item.ad_byte);
        if (in_item.packet_end) queue_name();
      end
      if (out_valid && out_ready) check_name_item();
    end
    pending = expected_chars.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the name extractor testbench: clock, reset, packet stimulus, output stalls, verdict
`timescale 1ns / 100ps

module tb_top;
  import adne_pkg::*;

  localparam int NAME_MAX     = 64;
  localparam int RANDOM_ITEMS = 180;
  localparam int PHASE_ITEMS  = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 8;
  localparam int LIMIT        = 1000000;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data  = CAP_RESET;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_item;

  int fail_count;
  int pending;
  int chars_checked;

  bit         calm = 1'b0;
  int         hold_asked = 0;
  int         hold_served = 0;
  int         cycle_count = 0;
  int         bytes_sent = 0;
  int         packets_sent = 0;
  int         settings_used = 1;
  logic [7:0] pkt [$];

  always #1 clk = ~clk;

  adv_data_name_extractor_unit #(.NAME_MAX(NAME_MAX)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  adne_checker #(.NAME_MAX(NAME_MAX)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .fail_count    (fail_count),
    .pending       (pending),
    .chars_checked (chars_checked)
  );

  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [7:0] value_byte();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(32, 126));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{ad_byte: b, packet_end: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_pkt();
    int i;
    for (i = 0; i < pkt.size(); i++) push_byte(pkt[i], i == pkt.size() - 1);
    packets_sent++;
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Drop valid and hold off until every name item has drained.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic build_packet(input bit force_long);
    int         nrec;
    int         pick;
    int         vlen;
    int         r;
    logic [7:0] rec_type;
    pkt.delete();
    if (!force_long && $urandom_range(0, 9) == 0) begin
      // raw noise
      repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom_range(0, 255)));
      return;
    end
    nrec = $urandom_range(1, 3);
    for (r = 0; r < nrec; r++) begin
      pick = $urandom_range(0, 9);
      if (pick == 9 && !(force_long && r == 0)) begin
        // zero length stops parsing; trailing bytes are ignored
        pkt.push_back(8'h00);
        repeat ($urandom_range(0, 2)) pkt.push_back(8'($urandom_range(0, 255)));
        break;
      end
      if (force_long && r == 0) rec_type = TYPE_COMPLETE;
      else if (pick < 4) rec_type = TYPE_COMPLETE;
      else if (pick < 7) rec_type = TYPE_SHORT;
      else rec_type = 8'($urandom_range(0, 255));
      if (force_long && r == 0) vlen = 70;
      else if ($urandom_range(0, 14) == 0) vlen = $urandom_range(40, 70);
      else vlen = $urandom_range(0, 8);
      pkt.push_back(8'(vlen + 1));
      pkt.push_back(rec_type);
      repeat (vlen) pkt.push_back(value_byte());
    end
    if ($urandom_range(0, 4) == 0) begin
      // record cut off by the packet end
      vlen = $urandom_range(3, 255);
      pkt.push_back(8'(vlen));
      pkt.push_back($urandom_range(0, 1) ? TYPE_COMPLETE : TYPE_SHORT);
      repeat ($urandom_range(0, 1)) pkt.push_back(value_byte());
    end
  endtask

  // Output side: random stall per item, plus one long hold-off on request.
  initial begin : drain
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_asked != hold_served) begin
        out_ready <= 1'b0;
        for (w = 0; w < HOLD_CYCLES; w++) @(negedge clk);
        hold_served++;
      end
      w = pick_gap();
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d name items still pending", cycle_count, pending);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int cap_plan [4];
    int phase;
    int rand_items;
    int phase_items;
    int cap;
    bit first;
    cap_plan = '{64, 63, 2, 1};
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed packets at the reset capacity
    pkt = '{8'h00};
    send_pkt();
    pkt = '{8'h03, 8'h09, 8'h41, 8'hFF};
    send_pkt();
    // shortened name replaced by a complete one
    pkt = '{8'h02, 8'h08, 8'h7E, 8'h02, 8'h09, 8'h1F};
    send_pkt();
    // complete name ends parsing; the trailing byte is ignored
    pkt = '{8'h02, 8'h09, 8'h20, 8'h05};
    send_pkt();
    // cut-off record leaves the earlier name in place
    pkt = '{8'h02, 8'h08, 8'h5A, 8'h05, 8'h09, 8'h41};
    send_pkt();
    // name record without value bytes is not taken
    pkt = '{8'h01, 8'h09, 8'h00};
    send_pkt();
    finish_phase();

    // capacity one: a taken name keeps no characters
    write_capacity(7'd1);
    pkt = '{8'h02, 8'h09, 8'h41};
    send_pkt();
    finish_phase();

    phase      = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      cap = (phase < 4) ? cap_plan[phase] : $urandom_range(1, 64);
      write_capacity(7'(cap));
      calm = (phase % 3 == 2);
      if (phase == 1) hold_asked++;
      phase_items = 0;
      first       = 1'b1;
      while (phase_items < PHASE_ITEMS && rand_items < RANDOM_ITEMS) begin
        build_packet(phase == 0 && first);
        first = 1'b0;
        send_pkt();
        phase_items += pkt.size();
        rand_items  += pkt.size();
      end
      finish_phase();
      phase++;
    end

    $display("Run covered %0d packets, %0d bytes, %0d capacity settings",
             packets_sent, bytes_sent, settings_used);
    $display("Checked %0d name items in %0d cycles", chars_checked, cycle_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/adne_pkg.sv
sv/adne_ctrl.sv
sv/adne_dp.sv
sv/adv_data_name_extractor_unit.sv
tb/adne_checker.sv
tb/tb_top.sv
